// File: rtl/key_velocity_curve_interp_assert.svh
// Assertion macros shared by the key velocity checkers.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef KEY_VELOCITY_CURVE_INTERP_ASSERT_SVH
`define KEY_VELOCITY_CURVE_INTERP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define KVCI_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key_velocity_curve_interp: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define KVCI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key_velocity_curve_interp: next-cycle check failed");

`endif

// File: rtl/kvci_pkg.sv
package kvci_pkg;

    // Field widths
    localparam int KEY_W     = 6;
    localparam int NOTE_W    = 7;
    localparam int TIME_W    = 32;
    localparam int VEL_W     = 14;
    localparam int CURVE_W   = 3;

    // Time axis of the curve
    localparam int FRAC_BITS = 13;
    localparam int IDX_W     = 6;
    localparam int SPAN_W    = FRAC_BITS + IDX_W;
    localparam logic [TIME_W-1:0] T_LOW  = 32'd2500;
    localparam logic [TIME_W-1:0] T_HIGH = 32'd526788;
    localparam int FRAC_ONE  = 1 << FRAC_BITS;

    // Curve table geometry
    localparam int LAST_ENTRY  = 64;
    localparam int NUM_ENTRIES = LAST_ENTRY + 1;
    localparam int ENTRY_IDX_W = 7;
    localparam int NUM_CURVES  = 5;
    localparam int VEL_MAX     = 16383;

    localparam logic [NOTE_W-1:0] NOTE_OFFSET = 7'd36;

    // Weighted sum of two entries, at most VEL_MAX * FRAC_ONE
    localparam int SUM_W = VEL_W + FRAC_BITS;

    typedef enum logic [CURVE_W-1:0] {
        CURVE_VERY_SOFT = 3'd0,
        CURVE_SOFT      = 3'd1,
        CURVE_NORMAL    = 3'd2,
        CURVE_HARD      = 3'd3,
        CURVE_VERY_HARD = 3'd4
    } curve_t;

    // Lookup request from the interpolator to the curve ROM
    typedef struct packed {
        curve_t           curve;
        logic [IDX_W-1:0] idx;
    } rom_req_t;

    // Two adjacent curve entries
    typedef struct packed {
        logic [VEL_W-1:0] lo;
        logic [VEL_W-1:0] hi;
    } rom_rsp_t;

endpackage

// File: rtl/kvci_curve_rom.sv
module kvci_curve_rom (
    input  kvci_pkg::rom_req_t req,
    output kvci_pkg::rom_rsp_t rsp
);
    import kvci_pkg::*;

    logic [VEL_W-1:0] rom_w [NUM_CURVES][NUM_ENTRIES];
    logic [ENTRY_IDX_W-1:0] idx_lo;
    logic [ENTRY_IDX_W-1:0] idx_hi;

    // Build the hyperbolic curves: shape b = p/8 with p = 1 << curve
    for (genvar c = 0; c < NUM_CURVES; c++) begin : g_curve
        for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_entry
            localparam int P     = 1 << c;
            localparam int DEN   = 8 + P * i;
            localparam int ENTRY = (VEL_MAX * (LAST_ENTRY - i) + 4 * DEN) / (8 * DEN);
            assign rom_w[c][i] = VEL_W'(ENTRY);
        end
    end

    // Read the two neighboring entries of the selected curve
    assign idx_lo = {1'b0, req.idx};
    assign idx_hi = idx_lo + 7'd1;
    assign rsp.lo = rom_w[req.curve][idx_lo];
    assign rsp.hi = rom_w[req.curve][idx_hi];

endmodule

// File: rtl/kvci_interp.sv
module kvci_interp (
    input  logic [kvci_pkg::CURVE_W-1:0] curve_sel,
    input  logic [kvci_pkg::TIME_W-1:0]  switch_time,
    output logic [kvci_pkg::VEL_W-1:0]   velocity
);
    import kvci_pkg::*;

    logic                 below;
    logic                 above;
    logic [SPAN_W-1:0]    delta;
    logic [FRAC_BITS-1:0] frac;
    logic [FRAC_BITS:0]   weight_lo;
    logic [SUM_W-1:0]     prod_lo;
    logic [SUM_W-1:0]     prod_hi;
    logic [SUM_W-1:0]     sum;
    curve_t               curve_map;
    rom_req_t             req;
    rom_rsp_t             rsp;

    // Map unknown curve codes onto the normal curve
    always_comb
    begin
        case (curve_sel)
            CURVE_VERY_SOFT: curve_map = CURVE_VERY_SOFT;
            CURVE_SOFT:      curve_map = CURVE_SOFT;
            CURVE_NORMAL:    curve_map = CURVE_NORMAL;
            CURVE_HARD:      curve_map = CURVE_HARD;
            CURVE_VERY_HARD: curve_map = CURVE_VERY_HARD;
            default:         curve_map = CURVE_NORMAL;
        endcase
    end

    assign req.curve = curve_map;

    // Split the offset time into table index and fraction
    assign below   = (switch_time <= T_LOW);
    assign above   = (switch_time >= T_HIGH);
    assign delta   = SPAN_W'(switch_time - T_LOW);
    assign req.idx = delta[SPAN_W-1:FRAC_BITS];
    assign frac    = delta[FRAC_BITS-1:0];

    kvci_curve_rom u_rom (
        .req (req),
        .rsp (rsp)
    );

    // Blend the two entries
    assign weight_lo = (FRAC_BITS+1)'(FRAC_ONE) - {1'b0, frac};
    assign prod_lo   = SUM_W'(rsp.lo) * SUM_W'(weight_lo);
    assign prod_hi   = SUM_W'(rsp.hi) * SUM_W'(frac);
    assign sum       = prod_lo + prod_hi;

    // Clamp outside the table span
    always_comb
    begin
        if (below)
        begin
            velocity = VEL_W'(VEL_MAX);
        end
        else if (above)
        begin
            velocity = '0;
        end
        else
        begin
            velocity = sum[SUM_W-1:FRAC_BITS];
        end
    end

endmodule

// File: rtl/key_velocity_curve_interp.sv
// Key velocity curve: each key event word (key index, release flag, switch time
// in microseconds) yields one result word with note number key+36, the release
// flag and a 14-bit velocity read from one of five hyperbolic curves and
// linearly interpolated with a 13-bit fraction; times up to 2500 us give 16383
// and times of 526788 us or more give 0. The curve is picked by the
// velocity_curve register (reset: normal; codes 5 to 7 act as normal), written
// through the cfg channel, which is always ready. One word is accepted every
// cycle while in_stall is low: an input register feeds the curve ROM and the
// two interpolation multipliers, whose result lands in the output register.
// in_stall rises only while both registers are full and the output is stalled.
module key_velocity_curve_interp (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kvci_pkg::CURVE_W-1:0]    velocity_curve,
    // Key events
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [kvci_pkg::KEY_W-1:0]      key_index,
    input  logic                            is_release,
    input  logic [kvci_pkg::TIME_W-1:0]     switch_time_us,
    // Results
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [kvci_pkg::NOTE_W-1:0]     note_number,
    output logic                            release_flag,
    output logic [kvci_pkg::VEL_W-1:0]      velocity
);
    import kvci_pkg::*;

    logic [CURVE_W-1:0] curve_reg;
    logic               s1_valid_reg;
    logic [KEY_W-1:0]   s1_key_reg;
    logic               s1_rel_reg;
    logic [TIME_W-1:0]  s1_time_reg;
    logic               out_valid_reg;
    logic [NOTE_W-1:0]  note_reg;
    logic               rel_reg;
    logic [VEL_W-1:0]   vel_reg;
    logic [VEL_W-1:0]   vel_next;
    logic               out_ready;
    logic               s1_ready;

    assign cfg_ready = 1'b1;

    // Write the curve select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_reg <= CURVE_NORMAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            curve_reg <= velocity_curve;
        end
    end

    // Stage handshake: each register advances when the one after it has room
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign in_stall  = !s1_ready;

    // Hold the accepted event word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_key_reg  <= key_index;
            s1_rel_reg  <= is_release;
            s1_time_reg <= switch_time_us;
        end
    end

    kvci_interp u_interp (
        .curve_sel   (curve_reg),
        .switch_time (s1_time_reg),
        .velocity    (vel_next)
    );

    // Advance the result word into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s1_valid_reg)
        begin
            note_reg <= NOTE_W'(s1_key_reg) + NOTE_OFFSET;
            rel_reg  <= s1_rel_reg;
            vel_reg  <= vel_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign note_number  = note_reg;
    assign release_flag = rel_reg;
    assign velocity     = vel_reg;

endmodule

// File: rtl/kvci_checker.sv
`include "key_velocity_curve_interp_assert.svh"

module kvci_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [kvci_pkg::NOTE_W-1:0]     note_number,
    input  logic                            release_flag,
    input  logic [kvci_pkg::VEL_W-1:0]      velocity
);
    import kvci_pkg::*;

    // Note numbers stay in the keyboard's range
    `KVCI_ASSERT_NOW(a_note_range, out_valid, (note_number >= 7'd36) && (note_number <= 7'd99))

    // Input backs up only behind a stalled, full output
    `KVCI_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // A new result follows an accepted word that passed through the input register
    `KVCI_ASSERT_NOW(a_rise_source, $rose(out_valid), $past(in_valid && !in_stall, 2))

    // A stalled result word holds
    `KVCI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(note_number) && $stable(release_flag) && $stable(velocity))

endmodule

bind key_velocity_curve_interp kvci_checker u_kvci_checker (.*);

// File: tb/key_velocity_curve_interp_test.sv
module key_velocity_curve_interp_test;
    timeunit 1ns;
    timeprecision 1ps;

    import kvci_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 192;
    localparam int NUM_PHASES     = 8;
    localparam int PRINT_LIMIT    = 40;

    // Register codes with no curve of their own; they fall back to normal
    localparam logic [CURVE_W-1:0] CURVE_SPARE_LOW = 3'd5;
    localparam logic [CURVE_W-1:0] CURVE_SPARE_MID = 3'd6;
    localparam logic [CURVE_W-1:0] CURVE_SPARE_TOP = 3'd7;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic              released;
        logic [TIME_W-1:0] switch_us;
    } key_event_t;

    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic              released;
        logic [VEL_W-1:0]  vel;
    } note_result_t;

    logic                clk;
    logic                rst_n          = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [CURVE_W-1:0]  velocity_curve = CURVE_NORMAL;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [KEY_W-1:0]    key_index      = '0;
    logic                is_release     = 1'b0;
    logic [TIME_W-1:0]   switch_time_us = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic [NOTE_W-1:0]   note_number;
    logic                release_flag;
    logic [VEL_W-1:0]    velocity;

    key_event_t          pending_events[$];
    note_result_t        expected_notes[$];
    key_event_t          taken_event;
    note_result_t        oldest_note;
    logic [CURVE_W-1:0]  curve_sel      = CURVE_NORMAL;
    logic [CURVE_W-1:0]  curve_plan[NUM_PHASES];
    logic                in_taken       = 1'b0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  events_issued  = 0;
    int                  events_accepted = 0;
    int                  mismatches     = 0;
    int                  quiet_cycles   = 0;

    key_velocity_curve_interp dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .velocity_curve (velocity_curve),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .key_index      (key_index),
        .is_release     (is_release),
        .switch_time_us (switch_time_us),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .note_number    (note_number),
        .release_flag   (release_flag),
        .velocity       (velocity)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Entry i of the curve with shape b = shape/8, rounded to nearest
    function automatic int unsigned curve_point(input int unsigned shape, input int unsigned i);
        int unsigned den;
        den = 8 + shape * i;
        return (VEL_MAX * (LAST_ENTRY - i) + 4 * den) / (8 * den);
    endfunction

    // Note, release flag and interpolated velocity for one key event
    function automatic note_result_t predict_note(input key_event_t ev,
                                                  input logic [CURVE_W-1:0] sel);
        int unsigned  shape;
        int unsigned  span;
        int unsigned  frac;
        int unsigned  idx;
        int unsigned  vel;
        note_result_t r;
        shape = (sel > CURVE_VERY_HARD) ? (1 << CURVE_NORMAL) : (1 << sel);
        if (ev.switch_us <= T_LOW)
            vel = curve_point(shape, 0);
        else if (ev.switch_us >= T_HIGH)
            vel = curve_point(shape, LAST_ENTRY);
        else
        begin
            span = ev.switch_us - T_LOW;
            frac = span % FRAC_ONE;
            idx  = span / FRAC_ONE;
            vel  = (curve_point(shape, idx) * (FRAC_ONE - frac)
                    + curve_point(shape, idx + 1) * frac) >> FRAC_BITS;
        end
        r.note     = NOTE_OFFSET + ev.key;
        r.released = ev.released;
        r.vel      = vel[VEL_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%0t velocity check: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    task automatic add_event(input int unsigned key, input bit rel, input int unsigned t);
        key_event_t ev;
        ev.key       = key[KEY_W-1:0];
        ev.released  = rel;
        ev.switch_us = t;
        pending_events.push_back(ev);
        events_issued++;
    endtask

    // Mostly in-range times, then edges, short times and raw 32-bit noise
    task automatic add_random_event();
        int unsigned roll;
        int unsigned t;
        roll = $urandom_range(99);
        if (roll < 70)
            t = T_LOW + 1 + $urandom_range(T_HIGH - T_LOW - 2);
        else if (roll < 80)
        begin
            case ($urandom_range(2))
                0:       t = T_LOW + $urandom_range(6) - 3;
                1:       t = T_HIGH + $urandom_range(6) - 3;
                default: t = T_LOW + ($urandom_range(LAST_ENTRY) << FRAC_BITS)
                             + $urandom_range(2) - 1;
            endcase
        end
        else if (roll < 90)
            t = $urandom_range(T_LOW);
        else
            t = $urandom();
        add_event($urandom_range(63), $urandom_range(1), t);
    endtask

    // Hold until every word is taken and every result is back
    task automatic drain();
        do
            @(negedge clk);
        while (events_accepted != events_issued || expected_notes.size() != 0);
        @(posedge clk);
    endtask

    task automatic write_curve(input logic [CURVE_W-1:0] code);
        @(negedge clk);
        cfg_valid      <= 1'b1;
        velocity_curve <= code;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        curve_sel = code;
        cfg_valid <= 1'b0;
    endtask

    // Driver: hold a stalled word, otherwise advance or idle
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                key_index      <= pending_events[0].key;
                is_release     <= pending_events[0].released;
                switch_time_us <= pending_events[0].switch_us;
                in_valid       <= 1'b1;
                void'(pending_events.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: predict on input accept, check each result word in order
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                taken_event.key       = key_index;
                taken_event.released  = is_release;
                taken_event.switch_us = switch_time_us;
                expected_notes.push_back(predict_note(taken_event, curve_sel));
                events_accepted <= events_accepted + 1;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_notes.size() == 0)
                    report_mismatch("result word with none expected, note", note_number, -1);
                else
                begin
                    oldest_note = expected_notes.pop_front();
                    if (note_number !== oldest_note.note)
                        report_mismatch("note_number", note_number, oldest_note.note);
                    if (release_flag !== oldest_note.released)
                        report_mismatch("release_flag", release_flag, oldest_note.released);
                    if (velocity !== oldest_note.vel)
                        report_mismatch("velocity", velocity, oldest_note.vel);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles with no handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("key_velocity_curve_interp: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        curve_plan = '{CURVE_VERY_SOFT, CURVE_SPARE_TOP, CURVE_VERY_HARD, CURVE_SOFT,
                       CURVE_SPARE_LOW, CURVE_HARD, CURVE_SPARE_MID, CURVE_NORMAL};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed words on the reset curve: time edges, segment edges, key extremes
        add_event(0, 0, 0);
        add_event(63, 1, 1);
        add_event(1, 0, T_LOW - 1);
        add_event(62, 1, T_LOW);
        add_event(0, 1, T_LOW + 1);
        add_event(63, 0, T_LOW + 2);
        add_event(21, 0, T_LOW + FRAC_ONE - 1);
        add_event(42, 1, T_LOW + FRAC_ONE);
        add_event(7, 0, T_LOW + 32 * FRAC_ONE + FRAC_ONE / 2);
        add_event(56, 1, T_LOW + 32'h2AAAA);
        add_event(35, 0, T_LOW + 32'h55555);
        add_event(28, 1, 32'd524288);
        add_event(63, 1, T_HIGH - 1);
        add_event(0, 0, T_HIGH);
        add_event(31, 1, T_HIGH + 1);
        add_event(32, 0, 32'h7FFF_FFFF);
        add_event(63, 1, 32'h8000_0000);
        add_event(0, 0, 32'hFFFF_FFFF);
        drain();

        // Random phases, each with its own curve and idling mix
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_curve(curve_plan[phase]);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            @(posedge clk);
            repeat (PHASE_WORDS / 2) add_random_event();
            // Pause the sender until the pipeline is empty
            drain();
            repeat (PHASE_WORDS - PHASE_WORDS / 2) add_random_event();
            drain();
        end

        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_notes.size() == 0)
            $display("key_velocity_curve_interp: match");
        else
            $display("key_velocity_curve_interp: mismatch");
        $finish;
    end

endmodule
